@@ sv/pixel_tint_shade_blend_macros.svh @@
`ifndef PIXEL_TINT_SHADE_BLEND_MACROS_SVH
`define PIXEL_TINT_SHADE_BLEND_MACROS_SVH

// concurrent check, switched off while reset is held
`define PTSB_ASSERT_DIS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// concurrent check that also runs through reset
`define PTSB_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ptsb_pkg.sv @@
package ptsb_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TINT_RED     = 3'd0,
        REG_TINT_GREEN   = 3'd1,
        REG_TINT_BLUE    = 3'd2,
        REG_BACK_RED     = 3'd3,
        REG_BACK_GREEN   = 3'd4,
        REG_BACK_BLUE    = 3'd5,
        REG_DISABLED     = 3'd6,
        REG_ALPHA_MODE   = 3'd7
    } t_cfg_idx;

    // code 3 is unused and acts like ALPHA_NONE
    typedef enum logic [1:0] {
        ALPHA_NONE  = 2'd0,
        ALPHA_COVER = 2'd1,
        ALPHA_BLEND = 2'd2
    } t_alpha_mode;

    function automatic logic [7:0] sat8(input logic [9:0] v);
        logic [7:0] res;
        res = (v > 10'd255) ? 8'hFF : v[7:0];
        return res;
    endfunction

endpackage

@@ sv/ptsb_chan.sv @@
module ptsb_chan (
    input  logic       i_clk,
    input  logic [8:0] i_tint,
    input  logic [7:0] i_scale,
    input  logic [8:0] i_add,
    input  logic [7:0] i_cov,
    input  logic [7:0] i_back,
    input  logic       i_blend,
    output logic [7:0] o_chan
);
    import ptsb_pkg::*;

    logic [16:0] w_shade_prod;
    logic [9:0]  w_shade_sum;
    logic [7:0]  r_shade;
    logic [15:0] w_fg_prod;
    logic [8:0]  w_inv_cov;
    logic [16:0] w_bg_prod;
    logic [9:0]  w_blend_sum;
    logic [7:0]  r_out;

    // shade stage: tint scaled in 256ths with rounding, plus light
    assign w_shade_prod = 17'(i_tint) * 17'(i_scale) + 17'd127;
    assign w_shade_sum  = 10'(w_shade_prod[16:8]) + 10'(i_add);

    // blend stage: shaded color over background by coverage
    assign w_fg_prod   = 16'(r_shade) * 16'(i_cov) + 16'd127;
    assign w_inv_cov   = 9'd256 - 9'(i_cov);
    assign w_bg_prod   = 17'(i_back) * 17'(w_inv_cov) + 17'd127;
    assign w_blend_sum = 10'(w_fg_prod[15:8]) + 10'(w_bg_prod[16:8]);

    always_ff @(posedge i_clk) begin
        r_shade <= sat8(w_shade_sum);
        r_out   <= i_blend ? sat8(w_blend_sum) : r_shade;
    end

    assign o_chan = r_out;

endmodule

@@ sv/pixel_tint_shade_blend.sv @@
// pixel_tint_shade_blend: tinted shading of one pixel per item
//
// input: drive i_shade_scale, i_shade_light and i_coverage with start high;
// the item is taken at a rising edge where start is high and busy is low.
// busy never rises, so a new item can be taken in every cycle.
// output: o_done is high for one cycle with o_out_red/green/blue/alpha;
// the receiver must take the item in that cycle, it cannot stall.
// o_done is registered: an item passes four register stages (input,
// tint/light, shade, blend) before o_done shows it.
// throughput: one item per cycle, set by the fully pipelined datapath.
// config: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data; ready
// is always high. write only while no item is in flight.
// reset: synchronous active low i_rst_n clears the config registers and
// all valid bits; no result is shown from an item in flight at reset.
module pixel_tint_shade_blend (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [7:0]                       i_shade_scale,
    input  logic [7:0]                       i_shade_light,
    input  logic [7:0]                       i_coverage,
    output logic                             o_done,
    output logic [7:0]                       o_out_red,
    output logic [7:0]                       o_out_green,
    output logic [7:0]                       o_out_blue,
    output logic [7:0]                       o_out_alpha,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ptsb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);
    import ptsb_pkg::*;

    logic [7:0] r_tint_red, r_tint_green, r_tint_blue;
    logic [7:0] r_back_red, r_back_green, r_back_blue;
    logic       r_disabled;
    logic [1:0] r_alpha_mode;

    logic       r_v1, r_v2, r_v3, r_v4;
    logic [7:0] r_scale1, r_light1, r_cov1;
    logic [8:0] r_tint_r2, r_tint_g2, r_tint_b2, r_add2;
    logic [7:0] r_scale2, r_cov2, r_cov3, r_alpha4;

    logic [12:0] w_gray_sum;
    logic [7:0]  w_gray;
    logic [9:0]  w_dr, w_dg, w_db;
    logic [15:0] w_dadd;
    logic [8:0]  w_tint_r, w_tint_g, w_tint_b, w_add;
    logic        w_accept;
    logic        w_blend;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_blend     = (r_alpha_mode == ALPHA_BLEND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint_red   <= '0;
            r_tint_green <= '0;
            r_tint_blue  <= '0;
            r_back_red   <= '0;
            r_back_green <= '0;
            r_back_blue  <= '0;
            r_disabled   <= 1'b0;
            r_alpha_mode <= ALPHA_NONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_TINT_RED:   r_tint_red   <= i_cfg_data;
                REG_TINT_GREEN: r_tint_green <= i_cfg_data;
                REG_TINT_BLUE:  r_tint_blue  <= i_cfg_data;
                REG_BACK_RED:   r_back_red   <= i_cfg_data;
                REG_BACK_GREEN: r_back_green <= i_cfg_data;
                REG_BACK_BLUE:  r_back_blue  <= i_cfg_data;
                REG_DISABLED:   r_disabled   <= i_cfg_data[0];
                REG_ALPHA_MODE: r_alpha_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // valid bits travel with the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // gray level of the tint color for disabled shading
    assign w_gray_sum = 13'(r_tint_red) * 13'd11 + 13'(r_tint_green) * 13'd16
                      + 13'(r_tint_blue) * 13'd5;
    assign w_gray     = w_gray_sum[12:5];
    assign w_dr       = 10'(r_tint_red) * 10'd3 + 10'(w_gray);
    assign w_dg       = 10'(r_tint_green) * 10'd3 + 10'(w_gray);
    assign w_db       = 10'(r_tint_blue) * 10'd3 + 10'(w_gray);
    assign w_dadd     = 16'(r_light1) * 16'(w_gray) + 16'd127;

    always_comb begin
        if (r_disabled) begin
            w_tint_r = 9'(w_dr[9:2]);
            w_tint_g = 9'(w_dg[9:2]);
            w_tint_b = 9'(w_db[9:2]);
            w_add    = 9'(w_dadd[15:8]);
        end else begin
            w_tint_r = 9'(r_tint_red) + 9'd2;
            w_tint_g = 9'(r_tint_green) + 9'd2;
            w_tint_b = 9'(r_tint_blue) + 9'd2;
            // light * 5 / 4 when a scale is given
            w_add    = (r_scale1 != 8'd0) ? 9'(r_light1) + 9'(r_light1[7:2])
                                          : 9'(r_light1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_scale1  <= i_shade_scale;
        r_light1  <= i_shade_light;
        r_cov1    <= i_coverage;
        r_tint_r2 <= w_tint_r;
        r_tint_g2 <= w_tint_g;
        r_tint_b2 <= w_tint_b;
        r_add2    <= w_add;
        r_scale2  <= r_scale1;
        r_cov2    <= r_cov1;
        r_cov3    <= r_cov2;
        r_alpha4  <= (r_alpha_mode == ALPHA_COVER) ? r_cov3 : 8'hFF;
    end

    ptsb_chan u_chan_red (
        .i_clk   (i_clk),
        .i_tint  (r_tint_r2),
        .i_scale (r_scale2),
        .i_add   (r_add2),
        .i_cov   (r_cov3),
        .i_back  (r_back_red),
        .i_blend (w_blend),
        .o_chan  (o_out_red)
    );

    ptsb_chan u_chan_green (
        .i_clk   (i_clk),
        .i_tint  (r_tint_g2),
        .i_scale (r_scale2),
        .i_add   (r_add2),
        .i_cov   (r_cov3),
        .i_back  (r_back_green),
        .i_blend (w_blend),
        .o_chan  (o_out_green)
    );

    ptsb_chan u_chan_blue (
        .i_clk   (i_clk),
        .i_tint  (r_tint_b2),
        .i_scale (r_scale2),
        .i_add   (r_add2),
        .i_cov   (r_cov3),
        .i_back  (r_back_blue),
        .i_blend (w_blend),
        .o_chan  (o_out_blue)
    );

    assign o_done      = r_v4;
    assign o_out_alpha = r_alpha4;

endmodule

@@ sv/ptsb_checker.sv @@
`include "pixel_tint_shade_blend_macros.svh"

module ptsb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // every accepted item comes out after a fixed latency
    `PTSB_ASSERT_DIS(a_done_after_accept, i_clk, i_rst_n, (start && !busy) |-> ##4 o_done, "accepted item gave no result")

    // no result without an earlier accepted item
    `PTSB_ASSERT_DIS(a_done_has_item, i_clk, i_rst_n, o_done |-> $past(start && !busy, 4), "result without an accepted item")

    // reset flushes the pipeline
    `PTSB_ASSERT(a_reset_flush, i_clk, !i_rst_n |=> !o_done, "result right after reset")

endmodule

bind pixel_tint_shade_blend ptsb_checker u_ptsb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);

@@ bench/tb_pixel_tint_shade_blend.sv @@
`timescale 1ns / 1ps

module tb_pixel_tint_shade_blend;
    import ptsb_pkg::*;

    localparam int N_RAND_PHASES = 12;
    localparam int N_RAND_ITEMS  = 1290;

    typedef struct packed {
        logic [7:0] scale;
        logic [7:0] light;
        logic [7:0] cov;
    } shade_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        t_cfg_idx   idx;
        logic [7:0] data;
    } reg_write_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic                 busy;
    logic [7:0]           i_shade_scale = 8'd0;
    logic [7:0]           i_shade_light = 8'd0;
    logic [7:0]           i_coverage    = 8'd0;
    logic                 o_done;
    logic [7:0]           o_out_red;
    logic [7:0]           o_out_green;
    logic [7:0]           o_out_blue;
    logic [7:0]           o_out_alpha;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [7:0]           i_cfg_data    = 8'd0;

    // shadow copy of the block's registers
    logic [7:0] tint_r, tint_g, tint_b;
    logic [7:0] back_r, back_g, back_b;
    logic       dis_look;
    logic [1:0] amode;

    shade_item_t pending_items[$];
    pixel_t      expected_px[$];
    reg_write_t  reg_writes[$];

    int error_count = 0;
    int burst_left  = 0;
    int gap_left    = 0;

    pixel_tint_shade_blend dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_shade_scale (i_shade_scale),
        .i_shade_light (i_shade_light),
        .i_coverage    (i_coverage),
        .o_done        (o_done),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clip255(input int unsigned v);
        return (v > 255) ? 255 : v;
    endfunction

    function automatic pixel_t shade_pixel(input logic [7:0] scale, input logic [7:0] light,
                                           input logic [7:0] cov);
        int unsigned tint [3];
        int unsigned back [3];
        int unsigned chan [3];
        int unsigned gray;
        int unsigned boost;
        pixel_t      px;
        tint[0] = tint_r;
        tint[1] = tint_g;
        tint[2] = tint_b;
        back[0] = back_r;
        back[1] = back_g;
        back[2] = back_b;
        gray = (11 * tint[0] + 16 * tint[1] + 5 * tint[2]) >> 5;
        if (dis_look) begin
            boost = (light * gray + 127) >> 8;
        end else if (scale != 0) begin
            boost = (light * 5) / 4;
        end else begin
            boost = light;
        end
        for (int k = 0; k < 3; k++) begin
            chan[k] = dis_look ? (3 * tint[k] + gray) >> 2 : tint[k] + 2;
            chan[k] = clip255(((chan[k] * scale + 127) >> 8) + boost);
            if (amode == ALPHA_BLEND) begin
                chan[k] = clip255(((chan[k] * cov + 127) >> 8)
                                  + ((back[k] * (256 - cov) + 127) >> 8));
            end
        end
        px.red   = 8'(chan[0]);
        px.green = 8'(chan[1]);
        px.blue  = 8'(chan[2]);
        px.alpha = (amode == ALPHA_COVER) ? cov : 8'hFF;
        return px;
    endfunction

    // register write channel, shadow follows each accepted write
    always @(posedge i_clk) begin : reg_drv
        reg_write_t w;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
            tint_r   = 8'd0;
            tint_g   = 8'd0;
            tint_b   = 8'd0;
            back_r   = 8'd0;
            back_g   = 8'd0;
            back_b   = 8'd0;
            dis_look = 1'b0;
            amode    = 2'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_TINT_RED:   tint_r   = i_cfg_data;
                    REG_TINT_GREEN: tint_g   = i_cfg_data;
                    REG_TINT_BLUE:  tint_b   = i_cfg_data;
                    REG_BACK_RED:   back_r   = i_cfg_data;
                    REG_BACK_GREEN: back_g   = i_cfg_data;
                    REG_BACK_BLUE:  back_b   = i_cfg_data;
                    REG_DISABLED:   dis_look = i_cfg_data[0];
                    REG_ALPHA_MODE: amode    = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_writes.size() != 0) begin
                    w = reg_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= w.idx;
                    i_cfg_data  <= w.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // pixel driver: bursts of items separated by random gaps
    always @(posedge i_clk) begin : pixel_drv
        shade_item_t it;
        logic        take;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            take = start && !busy;
            if (take) begin
                expected_px.push_back(shade_pixel(i_shade_scale, i_shade_light, i_coverage));
            end
            if (start && !take) begin
                // hold the item until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_items.size() != 0) begin
                it = pending_items.pop_front();
                start         <= 1'b1;
                i_shade_scale <= it.scale;
                i_shade_light <= it.light;
                i_coverage    <= it.cov;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : pixel_mon
        pixel_t got;
        pixel_t want;
        if (i_rst_n && o_done) begin
            got = '{o_out_red, o_out_green, o_out_blue, o_out_alpha};
            if (expected_px.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected pixel: r%0d g%0d b%0d a%0d",
                             got.red, got.green, got.blue, got.alpha);
            end else begin
                want = expected_px.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("pixel mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                                 want.red, want.green, want.blue, want.alpha,
                                 got.red, got.green, got.blue, got.alpha);
                end
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_item(input logic [7:0] scale, input logic [7:0] light,
                              input logic [7:0] cov);
        pending_items.push_back('{scale, light, cov});
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [7:0] data);
        reg_writes.push_back('{idx, data});
    endtask

    // wait until no item or write is left anywhere, then let the pipe drain
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || start || expected_px.size() != 0
               || reg_writes.size() != 0 || i_cfg_valid);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_colors(input logic [7:0] tr, input logic [7:0] tg, input logic [7:0] tb,
                              input logic [7:0] br, input logic [7:0] bg, input logic [7:0] bb);
        set_reg(REG_TINT_RED, tr);
        set_reg(REG_TINT_GREEN, tg);
        set_reg(REG_TINT_BLUE, tb);
        set_reg(REG_BACK_RED, br);
        set_reg(REG_BACK_GREEN, bg);
        set_reg(REG_BACK_BLUE, bb);
    endtask

    initial begin : stimulus
        int per_phase;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // registers at their reset values: normal look, no coverage
        queue_item(8'd0, 8'd0, 8'd0);
        queue_item(8'd255, 8'd255, 8'd255);
        queue_item(8'd0, 8'd255, 8'd0);
        queue_item(8'd128, 8'd1, 8'd77);
        wait_idle();

        // white tint, coverage to alpha; upper data bits must be dropped
        set_colors(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        set_reg(REG_DISABLED, 8'hFE);
        set_reg(REG_ALPHA_MODE, 8'hFD);
        wait_idle();
        queue_item(8'd255, 8'd255, 8'd0);
        queue_item(8'd255, 8'd0, 8'd255);
        queue_item(8'd1, 8'd3, 8'd128);
        wait_idle();

        // disabled look blended over a white background
        set_colors(8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255);
        set_reg(REG_DISABLED, 8'h01);
        set_reg(REG_ALPHA_MODE, 8'h02);
        wait_idle();
        queue_item(8'd255, 8'd255, 8'd0);
        queue_item(8'd255, 8'd255, 8'd255);
        queue_item(8'd0, 8'd200, 8'd128);
        queue_item(8'd77, 8'd0, 8'd1);
        wait_idle();

        // unused alpha code behaves like no coverage
        set_reg(REG_DISABLED, 8'h00);
        set_reg(REG_ALPHA_MODE, 8'hFF);
        wait_idle();
        queue_item(8'd0, 8'd255, 8'd255);
        queue_item(8'd200, 8'd100, 8'd50);
        queue_item(8'd255, 8'd255, 8'd255);
        wait_idle();

        per_phase = N_RAND_ITEMS / N_RAND_PHASES;
        for (int ph = 0; ph < N_RAND_PHASES; ph++) begin
            set_colors(rand_byte(), rand_byte(), rand_byte(),
                       rand_byte(), rand_byte(), rand_byte());
            set_reg(REG_DISABLED, {7'($urandom_range(0, 127)), 1'((ph / 4) % 2)});
            set_reg(REG_ALPHA_MODE, {6'($urandom_range(0, 63)), 2'(ph % 4)});
            wait_idle();
            for (int n = 0; n < per_phase; n++)
                queue_item(rand_byte(), rand_byte(), rand_byte());
            wait_idle();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
